// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Sizes, register and command codes, and the item passed from the front end
// to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int MaxWidth    = 1024;
    localparam int AddrW       = $clog2(MaxWidth);
    localparam int ColW        = 11;
    localparam int RowW        = 16;
    localparam int InRowW      = 17;
    localparam int PixW        = 8;
    localparam int CfgW        = 16;
    localparam int GradW       = 11;
    localparam int SumW        = 2 * GradW - 1;
    localparam int RootW       = 8;
    localparam int BitW        = $clog2(RootW);
    localparam int QDepth      = 4;
    localparam int QPtrW       = $clog2(QDepth);
    localparam int ResetWidth  = 640;
    localparam int ResetHeight = 480;

    localparam logic CmdPixel = 1'b0;
    localparam logic CmdFlush = 1'b1;

    localparam logic RegWidth  = 1'b0;
    localparam logic RegHeight = 1'b1;

    typedef struct packed {
        logic [PixW-1:0]  value;
        logic [AddrW-1:0] idx;
        logic             rd_up;
        logic             rd_lo;
        logic             started;
        logic             col0;
        logic             col1;
        logic             w1;
        logic             last;
    } sem_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sem_qstat_t;

endpackage

`default_nettype wire

// ===== hdl/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram: generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== hdl/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front: input classification and position tracking
// Holds the size registers and raster counters, drops items that have no
// effect and queues the others with everything the back end needs.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [sem_pkg::CfgW-1:0]    cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [sem_pkg::PixW-1:0]    s_axis_tdata,
    input  wire logic                        s_axis_tuser,
    input  wire logic                        clearing,
    input  wire sem_pkg::sem_qstat_t         q_stat,
    output logic                             push,
    output sem_pkg::sem_item_t               push_item
);

    logic [sem_pkg::ColW-1:0]   width_reg;
    logic [sem_pkg::RowW-1:0]   height_reg;
    logic [sem_pkg::ColW-1:0]   in_column_reg, in_column_next;
    logic [sem_pkg::InRowW-1:0] in_row_reg, in_row_next;
    logic [sem_pkg::ColW-1:0]   out_column_reg, out_column_next;
    logic [sem_pkg::RowW-1:0]   out_row_reg, out_row_next;

    logic [sem_pkg::ColW-1:0]   w_eff;
    logic [sem_pkg::RowW-1:0]   h_eff;
    logic                       accept;
    logic                       pixel_phase;
    logic                       drop;
    logic                       started;
    logic [sem_pkg::ColW-1:0]   in_column_inc;
    logic [sem_pkg::ColW-1:0]   out_column_inc;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = sem_pkg::ColW'(1);
        end
        else if (int'(width_reg) > sem_pkg::MaxWidth)
        begin
            w_eff = sem_pkg::ColW'(sem_pkg::MaxWidth);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? sem_pkg::RowW'(1) : height_reg;
    end

    assign s_axis_tready = !clearing && !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pixel_phase   = in_row_reg < {1'b0, h_eff};
    assign drop          = (out_row_reg >= h_eff)
                        || (pixel_phase && s_axis_tuser == sem_pkg::CmdFlush);
    assign started       = (in_row_reg >= sem_pkg::InRowW'(2))
                        || (in_row_reg == sem_pkg::InRowW'(1) && in_column_reg != '0);
    assign push          = accept && !drop;

    always_comb
    begin
        push_item.value   = pixel_phase ? s_axis_tdata : '0;
        push_item.idx     = (int'(in_column_reg) < sem_pkg::MaxWidth)
                          ? sem_pkg::AddrW'(in_column_reg)
                          : sem_pkg::AddrW'(sem_pkg::MaxWidth - 1);
        push_item.rd_up   = in_row_reg >= sem_pkg::InRowW'(2);
        push_item.rd_lo   = in_row_reg != '0;
        push_item.started = started;
        push_item.col0    = in_column_reg == '0;
        push_item.col1    = in_column_reg == sem_pkg::ColW'(1);
        push_item.w1      = w_eff == sem_pkg::ColW'(1);
        push_item.last    = (out_row_reg == h_eff - sem_pkg::RowW'(1))
                         && (out_column_reg == w_eff - sem_pkg::ColW'(1));
    end

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        in_column_inc   = in_column_reg + sem_pkg::ColW'(1);
        out_column_inc  = out_column_reg + sem_pkg::ColW'(1);
        if (push)
        begin
            if (started)
            begin
                if (out_column_inc >= w_eff)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + sem_pkg::RowW'(1);
                end
                else
                begin
                    out_column_next = out_column_inc;
                end
            end
            if (in_column_inc >= w_eff)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + sem_pkg::InRowW'(1);
            end
            else
            begin
                in_column_next = in_column_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= sem_pkg::ColW'(sem_pkg::ResetWidth);
            height_reg     <= sem_pkg::RowW'(sem_pkg::ResetHeight);
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sem_pkg::RegWidth:  width_reg  <= cfg_data[sem_pkg::ColW-1:0];
                    sem_pkg::RegHeight: height_reg <= cfg_data[sem_pkg::RowW-1:0];
                    default:            ;
                endcase
            end
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sem_queue.sv =====
// ----------------------------------------------------------------------------
// sem_queue: short item queue between front end and back end
// Four-entry FIFO in flip-flops with full and empty status.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sem_pkg::sem_item_t  push_item,
    input  wire logic                pop,
    output sem_pkg::sem_item_t       pop_item,
    output sem_pkg::sem_qstat_t      stat
);

    sem_pkg::sem_item_t           entry_reg [sem_pkg::QDepth];
    logic [sem_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [sem_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [sem_pkg::QPtrW:0]      count_reg, count_next;

    assign pop_item   = entry_reg[rd_ptr_reg];
    assign stat.full  = count_reg == (sem_pkg::QPtrW+1)'(sem_pkg::QDepth);
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (sem_pkg::QPtrW+1)'(1);
            2'b01:   count_next = count_reg - (sem_pkg::QPtrW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sem_pkg::QPtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sem_pkg::QPtrW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sem_back.sv =====
// ----------------------------------------------------------------------------
// sem_back: line stores, window and gradient magnitude
// Clears the line stores after reset, then per queued item reads and updates
// the stores, shifts the window and forms gx and gy; for an item that yields
// a result it squares and takes a bit-serial square root into the output
// register.
`default_nettype none

module sem_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sem_pkg::sem_qstat_t         q_stat,
    output logic                             pop,
    input  wire sem_pkg::sem_item_t          pop_item,
    output logic                             clearing,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [sem_pkg::PixW-1:0]         m_axis_tdata,
    output logic                             m_axis_tlast
);

    typedef enum logic [6:0] {
        B_CLEAR  = 7'b0000001,
        B_IDLE   = 7'b0000010,
        B_READ   = 7'b0000100,
        B_WRITE  = 7'b0001000,
        B_SQUARE = 7'b0010000,
        B_ROOT   = 7'b0100000,
        B_OUT    = 7'b1000000
    } back_state_t;

    back_state_t                       state_reg, state_next;
    logic [sem_pkg::AddrW-1:0]         clr_cnt_reg;
    sem_pkg::sem_item_t                cur_reg;
    logic [sem_pkg::PixW-1:0]          win_reg [9];
    logic signed [sem_pkg::GradW-1:0]  gx_reg, gy_reg;
    logic [sem_pkg::SumW-1:0]          sum_reg;
    logic [sem_pkg::RootW-1:0]         root_reg;
    logic [sem_pkg::BitW-1:0]          bit_reg;
    logic                              out_valid_reg;
    logic [sem_pkg::PixW-1:0]          out_data_reg;
    logic                              out_last_reg;

    logic                              ram_we;
    logic [sem_pkg::AddrW-1:0]         ram_addr;
    logic [sem_pkg::PixW-1:0]          up_wdata, lo_wdata, up_rdata, lo_rdata;
    logic [sem_pkg::PixW-1:0]          a, b;
    logic [sem_pkg::PixW-1:0]          l0, l1, l2, c0, c2, r0, r1, r2;
    logic [sem_pkg::GradW-2:0]         px, nx, py, ny;
    logic signed [sem_pkg::GradW-1:0]  gx, gy;
    logic signed [2*sem_pkg::GradW-1:0] sqx, sqy;
    logic [sem_pkg::RootW-1:0]         trial;
    logic [2*sem_pkg::RootW-1:0]       trial_sq;
    logic                              out_free;
    logic                              load_out;

    assign clearing = state_reg == B_CLEAR;
    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == B_OUT) && out_free;

    assign ram_we   = (state_reg == B_CLEAR) || (state_reg == B_WRITE);
    assign ram_addr = (state_reg == B_CLEAR) ? clr_cnt_reg : cur_reg.idx;
    assign up_wdata = (state_reg == B_CLEAR) ? '0 : b;
    assign lo_wdata = (state_reg == B_CLEAR) ? '0 : cur_reg.value;

    sem_ram #(.WIDTH(sem_pkg::PixW), .DEPTH(sem_pkg::MaxWidth)) u_upper (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (up_wdata),
        .rdata (up_rdata)
    );

    sem_ram #(.WIDTH(sem_pkg::PixW), .DEPTH(sem_pkg::MaxWidth)) u_lower (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (lo_wdata),
        .rdata (lo_rdata)
    );

    always_comb
    begin
        a = cur_reg.rd_up ? up_rdata : '0;
        b = cur_reg.rd_lo ? lo_rdata : '0;
        if (cur_reg.col0 ? cur_reg.w1 : cur_reg.col1)
        begin
            l0 = '0;
            l1 = '0;
            l2 = '0;
        end
        else
        begin
            l0 = win_reg[1];
            l1 = win_reg[4];
            l2 = win_reg[7];
        end
        c0 = win_reg[2];
        c2 = win_reg[8];
        if (cur_reg.col0)
        begin
            r0 = '0;
            r1 = '0;
            r2 = '0;
        end
        else
        begin
            r0 = a;
            r1 = b;
            r2 = cur_reg.value;
        end
        px = (sem_pkg::GradW-1)'(r0) + (sem_pkg::GradW-1)'({r1, 1'b0})
           + (sem_pkg::GradW-1)'(r2);
        nx = (sem_pkg::GradW-1)'(l0) + (sem_pkg::GradW-1)'({l1, 1'b0})
           + (sem_pkg::GradW-1)'(l2);
        py = (sem_pkg::GradW-1)'(l2) + (sem_pkg::GradW-1)'({c2, 1'b0})
           + (sem_pkg::GradW-1)'(r2);
        ny = (sem_pkg::GradW-1)'(l0) + (sem_pkg::GradW-1)'({c0, 1'b0})
           + (sem_pkg::GradW-1)'(r0);
        gx = signed'({1'b0, px}) - signed'({1'b0, nx});
        gy = signed'({1'b0, py}) - signed'({1'b0, ny});
    end

    assign sqx      = gx_reg * gx_reg;
    assign sqy      = gy_reg * gy_reg;
    assign trial    = root_reg | (sem_pkg::RootW'(1) << bit_reg);
    assign trial_sq = trial * trial;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == sem_pkg::AddrW'(sem_pkg::MaxWidth - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:   state_next = B_WRITE;
            B_WRITE:  state_next = cur_reg.started ? B_SQUARE : B_IDLE;
            B_SQUARE: state_next = B_ROOT;
            B_ROOT:
            begin
                if (sum_reg[sem_pkg::SumW-1:2*sem_pkg::RootW] != '0 || bit_reg == '0)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
        end
        if (state_reg == B_WRITE)
        begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (state_reg == B_SQUARE)
        begin
            sum_reg  <= sem_pkg::SumW'(sqx) + sem_pkg::SumW'(sqy);
            root_reg <= '0;
            bit_reg  <= sem_pkg::BitW'(sem_pkg::RootW - 1);
        end
        if (state_reg == B_ROOT)
        begin
            if (sum_reg[sem_pkg::SumW-1:2*sem_pkg::RootW] != '0)
            begin
                root_reg <= '1;
            end
            else
            begin
                if ({{(sem_pkg::SumW-2*sem_pkg::RootW){1'b0}}, trial_sq} <= sum_reg)
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - sem_pkg::BitW'(1);
            end
        end
        if (load_out)
        begin
            out_data_reg <= root_reg;
            out_last_reg <= cur_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + sem_pkg::AddrW'(1);
            end
            if (state_reg == B_WRITE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= a;
                win_reg[5] <= b;
                win_reg[8] <= cur_reg.value;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/sobel_edge_magnitude_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top: streaming 3x3 Sobel gradient magnitude
// Front end classifies input transactions, a four-entry queue decouples it
// from the back end that runs the line stores, window and square root.
//
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata pixel_value, tuser cmd
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata edge_magnitude, tlast last
// cfg       in         cfg_we                         cfg_index, cfg_data
//
// After reset the line stores are cleared; s_axis_tready is low meanwhile.
// An ignored transaction is dropped in the front end and never queued.
// In the back end an item that yields no result passes through pop, store read
// and store write; one with a result goes on through square, 8 root steps and
// output load, with a single root step when the squared sum saturates.
// The queue lets input run ahead; a stalled output holds the back end, and
// the input once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [sem_pkg::CfgW-1:0]  cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [sem_pkg::PixW-1:0]  s_axis_tdata,  // [7:0] pixel_value
    input  wire logic                      s_axis_tuser,  // [0] cmd
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [sem_pkg::PixW-1:0]       m_axis_tdata,  // [7:0] edge_magnitude
    output logic                           m_axis_tlast   // last_of_frame
);

    sem_pkg::sem_qstat_t q_stat;
    sem_pkg::sem_item_t  push_item;
    sem_pkg::sem_item_t  pop_item;
    logic                push;
    logic                pop;
    logic                clearing;

    sem_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    sem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    sem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop           (pop),
        .pop_item      (pop_item),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("queue push while full");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_no_out_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !m_axis_tvalid && q_stat.empty)
        else $error("output or queued item during line store clear");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming Sobel edge magnitude block
// A directed table covers the 1x1 image, clamped sizes, ignored ticks and
// saturated edges. Random frames of small sizes follow, with one full
// 1024-wide row. Frames are chained by register writes between them. A local
// model of the line stores and the window predicts each output that the table does not fix.
// ----------------------------------------------------------------------------

module tb;

    localparam int ItemsGoal   = 1350;
    localparam int DrainCycles = 64;

    typedef struct packed {
        logic [sem_pkg::PixW-1:0] mag;
        logic                     last;
    } edge_res_t;

    typedef enum logic {RowCfg, RowItem} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        sel;
        logic [15:0] val;
        bit          fixed;
        edge_res_t   res;
    } plan_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [sem_pkg::CfgW-1:0]     cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [sem_pkg::PixW-1:0]     s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [sem_pkg::PixW-1:0]     m_axis_tdata;
    logic                         m_axis_tlast;

    logic [7:0]  sb_upper [sem_pkg::MaxWidth];
    logic [7:0]  sb_lower [sem_pkg::MaxWidth];
    logic [7:0]  sb_win [9];
    logic [10:0] sb_in_col;
    logic [16:0] sb_in_row;
    logic [10:0] sb_out_col;
    logic [15:0] sb_out_row;
    logic [10:0] sb_width;
    logic [15:0] sb_height;

    edge_res_t edge_expect[$];
    plan_row_t plan[$];
    int        mismatches;
    int        items_used;
    bit        calm;
    bit        gaps;
    bit        hold_req;
    int        stall_left;
    int        stall_pct;

    sobel_edge_magnitude_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int eff_height();
        return (sb_height == 0) ? 1 : int'(sb_height);
    endfunction

    function automatic logic [7:0] root_sat(input int s);
        int r;
        if (s >= 65536)
            return 8'd255;
        r = 255;
        while (r * r > s)
            r--;
        return r[7:0];
    endfunction

    function automatic bit advance_sobel(input logic cmd, input logic [7:0] pix,
                                         output edge_res_t res);
        int w;
        int h;
        int v;
        int idx;
        int a;
        int b;
        int gx;
        int gy;
        int lc[3];
        int cc[3];
        int rc[3];
        bit pix_phase;
        bit started;
        w = (sb_width == 0) ? 1 : int'(sb_width);
        if (w > sem_pkg::MaxWidth)
            w = sem_pkg::MaxWidth;
        h = eff_height();
        res = '0;
        if (sb_out_row >= h)
            return 1'b0;
        pix_phase = sb_in_row < h;
        if (pix_phase && cmd == sem_pkg::CmdFlush)
            return 1'b0;
        v = pix_phase ? int'(pix) : 0;
        started = sb_in_row >= 2 || (sb_in_row == 1 && sb_in_col >= 1);
        idx = (sb_in_col < sem_pkg::MaxWidth) ? int'(sb_in_col) : sem_pkg::MaxWidth - 1;
        a = (sb_in_row >= 2) ? int'(sb_upper[idx]) : 0;
        b = (sb_in_row >= 1) ? int'(sb_lower[idx]) : 0;
        sb_upper[idx] = b[7:0];
        sb_lower[idx] = v[7:0];

        // column 0 closes the previous row: old window, zero right column
        if (started && sb_in_col == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lc[i] = (w == 1) ? 0 : int'(sb_win[i*3+1]);
                cc[i] = int'(sb_win[i*3+2]);
                rc[i] = 0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sb_win[i*3]   = sb_win[i*3+1];
            sb_win[i*3+1] = sb_win[i*3+2];
        end
        sb_win[2] = a[7:0];
        sb_win[5] = b[7:0];
        sb_win[8] = v[7:0];
        if (started && sb_in_col != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lc[i] = (sb_in_col == 1) ? 0 : int'(sb_win[i*3]);
                cc[i] = int'(sb_win[i*3+1]);
                rc[i] = int'(sb_win[i*3+2]);
            end
        end

        if (started)
        begin
            gx = (rc[0] + 2 * rc[1] + rc[2]) - (lc[0] + 2 * lc[1] + lc[2]);
            gy = (lc[2] + 2 * cc[2] + rc[2]) - (lc[0] + 2 * cc[0] + rc[0]);
            res.mag = root_sat(gx * gx + gy * gy);
            res.last = (sb_out_row == h - 1) && (sb_out_col == w - 1);
            sb_out_col = sb_out_col + 1'b1;
            if (sb_out_col >= w)
            begin
                sb_out_col = '0;
                sb_out_row = sb_out_row + 1'b1;
            end
        end

        sb_in_col = sb_in_col + 1'b1;
        if (sb_in_col >= w)
        begin
            sb_in_col = '0;
            sb_in_row = sb_in_row + 1'b1;
        end
        return started;
    endfunction

    function automatic plan_row_t plan_row(input row_kind_t kind, input logic sel,
                                           input logic [15:0] val, input bit fixed,
                                           input logic [7:0] mag, input logic last);
        plan_row_t r;
        r.kind = kind;
        r.sel = sel;
        r.val = val;
        r.fixed = fixed;
        r.res.mag = mag;
        r.res.last = last;
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] pix,
                             input bit fixed, input edge_res_t typed);
        bit        got;
        edge_res_t res;
        if (!calm && gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = advance_sobel(cmd, pix, res);
        items_used++;
        if (got)
            edge_expect.push_back(fixed ? typed : res);
        @(negedge clk);
    endtask

    task automatic drain_out();
        s_axis_tvalid <= 1'b0;
        while (edge_expect.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == sem_pkg::RegWidth)
            sb_width = val[10:0];
        else
            sb_height = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (edge_expect.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output: expected none, actual mag %0d last %0d",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                if (m_axis_tdata !== edge_expect[0].mag
                    || m_axis_tlast !== edge_expect[0].last)
                begin
                    mismatches++;
                    $display("%0t: output mismatch: expected mag %0d last %0d,",
                             $time, edge_expect[0].mag, edge_expect[0].last,
                             " actual mag %0d last %0d", m_axis_tdata, m_axis_tlast);
                end
                void'(edge_expect.pop_front());
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        stall_left = 0;
        stall_pct = 15;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = $urandom_range(60, 100);
            end
            if ($urandom_range(0, 255) == 0)
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 5);
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        int          phase_no;
        int          n_open;
        int          noise;
        bit          big;
        bit          open_frame;
        logic [15:0] w_data;
        logic [15:0] h_data;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sem_pkg::RegWidth;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = sem_pkg::CmdPixel;
        mismatches = 0;
        items_used = 0;
        calm = 1'b0;
        gaps = 1'b1;
        hold_req = 1'b0;
        phase_no = 0;

        for (int i = 0; i < sem_pkg::MaxWidth; i++)
        begin
            sb_upper[i] = '0;
            sb_lower[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            sb_win[i] = '0;
        sb_in_col = '0;
        sb_in_row = '0;
        sb_out_col = '0;
        sb_out_row = '0;
        sb_width = 11'(sem_pkg::ResetWidth);
        sb_height = 16'(sem_pkg::ResetHeight);

        // single-pixel image: zero sizes clamp to 1, magnitude is always 0
        plan.push_back(plan_row(RowCfg, sem_pkg::RegWidth, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowCfg, sem_pkg::RegHeight, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd200, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b1, 8'd0, 1'b1));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd77, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        // reopen the frame: flush tick in pixel phase, then pixels in the last row and past the image
        plan.push_back(plan_row(RowCfg, sem_pkg::RegWidth, 16'd3, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowCfg, sem_pkg::RegHeight, 16'd4, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd123, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));
        // oversized registers: width clamps to the line store size
        plan.push_back(plan_row(RowCfg, sem_pkg::RegWidth, 16'hFFFF, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowCfg, sem_pkg::RegHeight, 16'hFFFF, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdPixel, 16'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(plan_row(RowItem, sem_pkg::CmdFlush, 16'd0, 1'b0, 8'd0, 1'b0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == RowCfg)
            begin
                drain_out();
                write_reg(plan[i].sel, plan[i].val);
            end
            else
                send_item(plan[i].sel, plan[i].val[7:0], plan[i].fixed, plan[i].res);
        end

        while (items_used < ItemsGoal)
        begin
            phase_no++;
            big = (phase_no == 4);
            open_frame = !big && ($urandom_range(0, 7) == 0);
            if (big)
                w_data = 16'(sem_pkg::MaxWidth);
            else if ($urandom_range(0, 9) == 0)
                w_data = 16'd0;
            else
                w_data = 16'($urandom_range(1, 12));
            if (open_frame)
                h_data = 16'($urandom_range(int'(sb_out_row) + 50, 65535));
            else
                h_data = sb_out_row + (big ? 16'd1 : 16'($urandom_range(1, 4)));

            drain_out();
            write_reg(sem_pkg::RegWidth, w_data);
            write_reg(sem_pkg::RegHeight, h_data);
            calm = items_used > ItemsGoal * 85 / 100;
            gaps = ($urandom_range(0, 2) != 0);
            if (phase_no == 2 || big)
                hold_req = 1'b1;

            n_open = $urandom_range(10, 40);
            while (sb_out_row < eff_height() && (!open_frame || n_open > 0))
            begin
                if (sb_in_row < eff_height())
                    send_item(($urandom_range(0, 19) == 0) ? sem_pkg::CmdFlush
                                                           : sem_pkg::CmdPixel,
                              random_pixel(), 1'b0, '0);
                else
                    send_item(($urandom_range(0, 4) == 0) ? sem_pkg::CmdPixel
                                                          : sem_pkg::CmdFlush,
                              random_pixel(), 1'b0, '0);
                n_open--;
            end
            noise = $urandom_range(0, 2);
            repeat (noise)
                send_item(1'($urandom), 8'($urandom), 1'b0, '0);
        end

        calm = 1'b1;
        drain_out();
        if (mismatches == 0 && edge_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
